### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, also while reset is high.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

// Implication checked outside reset only.
`define ASSERT_RUN(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`endif

### hdl/llir_pkg.sv
// Types, constants and helpers of the least-loaded interrupt router.
package llir_pkg;

   // Sizes
   localparam int NUM_CORES      = 16;
   localparam int NUM_IRQS       = 16;
   localparam int BALANCE_PERIOD = 10;

   localparam int COUNT_W    = 64;
   localparam int FIELD_W    = 4;
   localparam int ACTIVE_W   = 5;
   localparam int CORE_W     = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
   localparam int IRQ_W      = (NUM_IRQS > 1) ? $clog2(NUM_IRQS) : 1;
   localparam int ADDR_W     = CORE_W + IRQ_W;
   localparam int DEPTH      = 2 ** ADDR_W;
   localparam int CORE_CNT_W = $clog2(NUM_CORES + 1);
   localparam int CLAMP_W    = (CORE_CNT_W > ACTIVE_W) ? CORE_CNT_W : ACTIVE_W;
   localparam int RANGE_W    = (CLAMP_W > FIELD_W) ? CLAMP_W : FIELD_W;
   localparam int IRQ_CNT_W  = $clog2(NUM_IRQS + 1);
   localparam int IRANGE_W   = (IRQ_CNT_W > FIELD_W) ? IRQ_CNT_W : FIELD_W;
   localparam int BEST_EXT_W = (CORE_W > FIELD_W) ? CORE_W : FIELD_W;
   localparam int RES_W      = (BALANCE_PERIOD > 1) ? $clog2(BALANCE_PERIOD) : 1;

   localparam logic [COUNT_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [COUNT_W-1:0] NEAR_MAX = 64'hFFFF_FFFF_FFFF_FFFE;

   // Register indexes of the csr port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SYM_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAL_EN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE   = 2'd2;

   typedef struct packed {
      logic [FIELD_W-1:0] core_id;
      logic [FIELD_W-1:0] irq;
   } req_type;

   typedef struct packed {
      logic               eoi_to_apic;
      logic               route_valid;
      logic [FIELD_W-1:0] route_core;
      logic               counts_cleared;
   } rsp_type;

   typedef struct packed {
      logic                symmetric_io_mode;
      logic                balance_enable;
      logic [ACTIVE_W-1:0] active_cores;
   } cfg_type;

   // Counter memory access from the sequencer
   typedef struct packed {
      logic                  rd_en;
      logic [ADDR_W-1:0]     rd_addr;
      logic                  wr_en;
      logic [ADDR_W-1:0]     wr_addr;
      logic [COUNT_W-1:0]    wr_data;
      logic                  clr_en;
      logic [IRQ_W-1:0]      clr_irq;
      logic [CORE_CNT_W-1:0] clr_n;
   } mem_req_type;

   // Chosen core index masked to the route field
   function automatic logic [FIELD_W-1:0] route_of(input logic [CORE_W-1:0] best);
      logic [BEST_EXT_W-1:0] ext;
      ext = BEST_EXT_W'(best);
      return ext[FIELD_W-1:0];
   endfunction

endpackage

### hdl/llir_cnt_mem.sv
// Interrupt count memory with per-entry valid bits and per-IRQ row clear.
module llir_cnt_mem (
   input  logic                         clock,
   input  logic                         reset,
   input  llir_pkg::mem_req_type        mem_req,
   output logic [llir_pkg::COUNT_W-1:0] rd_data
);
   import llir_pkg::*;

   logic [COUNT_W-1:0] mem_ff [DEPTH];
   logic [COUNT_W-1:0] rd_q_ff;
   logic               rd_vld_ff;
   logic [DEPTH-1:0]   vld_ff;
   logic [DEPTH-1:0]   vld_in;

   // Storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_q_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   // Valid bits: set on write, cleared per IRQ row; invalid entries read zero
   always_comb begin
      vld_in = vld_ff;
      if (mem_req.wr_en) begin
         vld_in[mem_req.wr_addr] = 1'b1;
      end
      if (mem_req.clr_en) begin
         for (int c = 0; c < NUM_CORES; c++) begin
            if (CORE_CNT_W'(c) < mem_req.clr_n) begin
               vld_in[{mem_req.clr_irq, CORE_W'(c)}] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (mem_req.rd_en) begin
            rd_vld_ff <= vld_ff[mem_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

### hdl/llir_mod_unit.sv
// Residue of a count by the balance period, one 16-bit chunk at a time, MSB first.
module llir_mod_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [llir_pkg::COUNT_W-1:0] value,
   output logic                         done,
   output logic                         multiple
);
   import llir_pkg::*;

   localparam int CHUNK_W = 16;
   localparam int CHUNKS  = COUNT_W / CHUNK_W;
   localparam int STEP_W  = $clog2(CHUNKS);
   localparam int X_W     = RES_W + CHUNK_W;
   localparam int SHIFT   = (BALANCE_PERIOD > 1) ? 32 + $clog2(BALANCE_PERIOD) : 32;
   localparam int RECIP_W = 34;
   localparam int PROD_W  = X_W + RECIP_W;
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SHIFT) + 64'(BALANCE_PERIOD) - 64'd1) / 64'(BALANCE_PERIOD);
   localparam logic [RECIP_W-1:0] RECIP  = RECIP_WIDE[RECIP_W-1:0];
   localparam logic [X_W-1:0]     PERIOD = X_W'(BALANCE_PERIOD);

   logic               run_ff;
   logic               phase_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [COUNT_W-1:0] shift_ff;
   logic [RES_W-1:0]   res_ff;
   logic [RES_W-1:0]   res_in;
   logic [X_W-1:0]     x_ff;
   logic [X_W-1:0]     x_in;
   logic [X_W-1:0]     q_ff;
   logic [X_W-1:0]     q_in;
   logic [PROD_W-1:0]  prod;
   logic [X_W-1:0]     qp;
   logic [X_W-1:0]     diff;
   logic               done_ff;
   logic               mult_ff;

   // Partial value is the running residue followed by the next chunk, MSB first;
   // its quotient comes from a multiply by the rounded-up reciprocal
   always_comb begin
      x_in = {res_ff, shift_ff[COUNT_W-1 -: CHUNK_W]};
      prod = PROD_W'(x_in) * PROD_W'(RECIP);
      q_in = X_W'(prod >> SHIFT);
   end

   // Remainder of the registered partial value
   always_comb begin
      qp     = q_ff * PERIOD;
      diff   = x_ff - qp;
      res_in = diff[RES_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && phase_ff && step_ff == STEP_W'(CHUNKS - 1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Quotient cycle, then remainder cycle, for each chunk
   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff <= value;
         res_ff   <= '0;
         step_ff  <= '0;
         phase_ff <= 1'b0;
      end else if (run_ff) begin
         if (!phase_ff) begin
            x_ff     <= x_in;
            q_ff     <= q_in;
            phase_ff <= 1'b1;
         end else begin
            res_ff   <= res_in;
            shift_ff <= {shift_ff[COUNT_W-CHUNK_W-1:0], CHUNK_W'(0)};
            step_ff  <= step_ff + 1'b1;
            phase_ff <= 1'b0;
            mult_ff  <= (res_in == '0);
         end
      end
   end

   assign done     = done_ff;
   assign multiple = mult_ff;

endmodule

### hdl/llir_ctrl.sv
// Sequencer: read-modify-write of one count, period check, minimum scan.
module llir_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  llir_pkg::req_type             req_data,
   input  llir_pkg::cfg_type             cfg,
   output llir_pkg::mem_req_type         mem_req,
   input  logic [llir_pkg::COUNT_W-1:0]  rd_data,
   output logic                          mod_start,
   output logic [llir_pkg::COUNT_W-1:0]  mod_value,
   input  logic                          mod_done,
   input  logic                          mod_multiple,
   output logic                          rsp_valid,
   output llir_pkg::rsp_type             rsp_data
);
   import llir_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_INC  = 3'd2;
   localparam logic [2:0] ST_MOD  = 3'd3;
   localparam logic [2:0] ST_SCAN = 3'd4;
   localparam logic [2:0] ST_LAST = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [CORE_W-1:0]     core_ff;
   logic [IRQ_W-1:0]      irq_ff;
   logic                  eoi_ff;
   logic [CORE_W-1:0]     idx_ff, idx_in;
   logic [CORE_W-1:0]     cmp_idx_ff;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [COUNT_W-1:0]    min_ff;
   logic [CORE_W-1:0]     best_ff;
   logic                  clear_ff;
   logic                  decided_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;
   logic [CORE_CNT_W-1:0] scan_n;
   logic [COUNT_W-1:0]    count_next;
   logic                  in_range;
   logic                  accept;
   logic                  last_issue;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Active core count clamped to the core array
   always_comb begin
      if (CLAMP_W'(cfg.active_cores) > CLAMP_W'(NUM_CORES)) begin
         scan_n = CORE_CNT_W'(NUM_CORES);
      end else begin
         scan_n = CORE_CNT_W'(cfg.active_cores);
      end
   end

   assign in_range = (RANGE_W'(req_data.core_id) < RANGE_W'(NUM_CORES))
                  && (IRANGE_W'(req_data.irq) < IRANGE_W'(NUM_IRQS));

   assign count_next = rd_data + 1'b1;
   assign last_issue = (CORE_CNT_W'(idx_ff) + CORE_CNT_W'(1)) == scan_n;

   // Next state and memory requests
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      cmp_vld_in = 1'b0;
      mem_req    = '0;
      mem_req.rd_addr = {irq_ff, core_ff};
      mem_req.wr_addr = {irq_ff, core_ff};
      mem_req.wr_data = count_next;
      mem_req.clr_irq = irq_ff;
      mem_req.clr_n   = scan_n;
      mod_start  = 1'b0;
      mod_value  = count_next;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = in_range ? ST_READ : ST_DONE;
            end
         end
         ST_READ: begin
            mem_req.rd_en = 1'b1;
            state_in      = ST_INC;
         end
         ST_INC: begin
            mem_req.wr_en = 1'b1;
            if (cfg.balance_enable && count_next != '0) begin
               mod_start = 1'b1;
               state_in  = ST_MOD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MOD: begin
            idx_in = '0;
            if (mod_done) begin
               if (!mod_multiple || scan_n == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = {irq_ff, idx_ff};
            cmp_vld_in      = 1'b1;
            if (last_issue) begin
               state_in = ST_LAST;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            mem_req.clr_en = clear_ff;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= (state_ff == ST_DONE);
      end
   end

   // Request fields and scan results
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmp_idx_ff <= idx_ff;
      if (accept) begin
         core_ff    <= CORE_W'(req_data.core_id);
         irq_ff     <= IRQ_W'(req_data.irq);
         eoi_ff     <= cfg.symmetric_io_mode;
         decided_ff <= 1'b0;
         clear_ff   <= 1'b0;
         best_ff    <= '0;
      end
      if (state_ff == ST_MOD && mod_done && mod_multiple) begin
         decided_ff <= 1'b1;
         min_ff     <= ALL_ONES;
         best_ff    <= '0;
         clear_ff   <= 1'b0;
      end
      // Strict minimum keeps the first lowest core
      if (cmp_vld_ff) begin
         if (rd_data < min_ff) begin
            min_ff  <= rd_data;
            best_ff <= cmp_idx_ff;
         end else if (rd_data >= NEAR_MAX) begin
            clear_ff <= 1'b1;
         end
      end
      if (state_ff == ST_DONE) begin
         rsp_ff.eoi_to_apic    <= eoi_ff;
         rsp_ff.route_valid    <= decided_ff;
         rsp_ff.route_core     <= decided_ff ? route_of(best_ff) : '0;
         rsp_ff.counts_cleared <= decided_ff && clear_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hdl/least_loaded_interrupt_router.sv
// Top level of the least-loaded interrupt router.
//
//   port group  direction  handshake               contents
//   req_        in         start & !busy           core_id, irq
//   rsp_        out        rsp_valid, one cycle    eoi_to_apic, route, clear flag
//   csr_        in         csr_valid & csr_ready   register index, write data
//
// One request at a time; busy is high after accept and low again in the result cycle.
// Out-of-range core or IRQ: straight from accept to the result; in range with
// balancing off: read, increment, result. With balancing on, the residue unit
// (four 16-bit chunks, each a quotient step then a remainder step, plus done)
// follows the increment; a rebalance adds one memory read per scanned core.
// The result strobe is a single cycle and cannot be stalled. Reset clears all
// counts at once through per-entry valid bits; no sweep.
module least_loaded_interrupt_router (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  llir_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output llir_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [llir_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [llir_pkg::CSR_DATA_W-1:0] csr_data
);
   import llir_pkg::*;

   cfg_type            cfg_ff;
   mem_req_type        mem_req;
   logic [COUNT_W-1:0] rd_data;
   logic               mod_start;
   logic [COUNT_W-1:0] mod_value;
   logic               mod_done;
   logic               mod_multiple;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.symmetric_io_mode <= 1'b0;
         cfg_ff.balance_enable    <= 1'b0;
         cfg_ff.active_cores      <= ACTIVE_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SYM_MODE: cfg_ff.symmetric_io_mode <= csr_data[0];
            CSR_BAL_EN:   cfg_ff.balance_enable    <= csr_data[0];
            CSR_ACTIVE:   cfg_ff.active_cores      <= csr_data[ACTIVE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   llir_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .cfg          (cfg_ff),
      .mem_req      (mem_req),
      .rd_data      (rd_data),
      .mod_start    (mod_start),
      .mod_value    (mod_value),
      .mod_done     (mod_done),
      .mod_multiple (mod_multiple),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

   llir_cnt_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   llir_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .value    (mod_value),
      .done     (mod_done),
      .multiple (mod_multiple)
   );

endmodule

### hdl/llir_checker.sv
// Port-level checker for the interrupt router and its bind.
`include "assert_macros.svh"

module llir_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input llir_pkg::rsp_type rsp_data
);
   import llir_pkg::*;

   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !busy && !rsp_valid, "not idle after reset")
   `ASSERT_RUN(a_accept_busy, clock, reset, start && !busy |=> busy, "accepted request left block idle")
   `ASSERT_RUN(a_single_strobe, clock, reset, rsp_valid |=> !rsp_valid, "result strobe longer than one cycle")
   `ASSERT_RUN(a_rsp_idle, clock, reset, rsp_valid |-> !busy, "result shown while request in flight")
   `ASSERT_RUN(a_route_fields, clock, reset, rsp_valid && !rsp_data.route_valid |-> rsp_data.route_core == '0 && !rsp_data.counts_cleared, "route fields set without decision")

endmodule

bind least_loaded_interrupt_router llir_checker u_llir_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

### tb/tb_least_loaded_interrupt_router.sv
// Self-checking testbench for the least-loaded interrupt router.
`timescale 1ns / 1ps

module tb_least_loaded_interrupt_router;
   import llir_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES = 200;
   localparam int RAND_PHASES = 8;
   localparam int PHASE_ITEMS = 128;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Predictor state: per core/IRQ counts and a copy of the registers
   logic [COUNT_W-1:0] irq_counts [NUM_CORES][NUM_IRQS];
   logic cfg_sym;
   logic cfg_bal;
   logic [ACTIVE_W-1:0] cfg_active;

   req_type pending_requests[$];
   rsp_type expected_routing[$];
   logic req_taken = 1'b0;
   int gap_left = 0;
   int gap_max = 12;
   int errors = 0;
   int cycle_count = 0;

   least_loaded_interrupt_router dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Count one serviced interrupt and work out the EOI target and any reroute
   function automatic rsp_type route_request(input req_type r);
      rsp_type res;
      logic [COUNT_W-1:0] tally;
      logic [COUNT_W-1:0] lowest;
      logic [COUNT_W-1:0] seen;
      int span;
      int best;
      logic wipe;
      res = '0;
      res.eoi_to_apic = cfg_sym;
      if (int'(r.core_id) < NUM_CORES && int'(r.irq) < NUM_IRQS) begin
         tally = irq_counts[r.core_id][r.irq] + 1'b1;
         irq_counts[r.core_id][r.irq] = tally;
         if (tally != '0 && tally % COUNT_W'(BALANCE_PERIOD) == '0 && cfg_bal) begin
            span = (cfg_active > NUM_CORES) ? NUM_CORES : int'(cfg_active);
            lowest = ALL_ONES;
            best = 0;
            wipe = 1'b0;
            // first core with the strictly lowest count wins
            for (int i = 0; i < span; i++) begin
               seen = irq_counts[i][r.irq];
               if (seen < lowest) begin
                  lowest = seen;
                  best = i;
               end else if (seen >= NEAR_MAX) begin
                  wipe = 1'b1;
               end
            end
            res.route_valid = 1'b1;
            res.route_core = best[FIELD_W-1:0];
            if (wipe) begin
               for (int i = 0; i < span; i++)
                  irq_counts[i][r.irq] = '0;
               res.counts_cleared = 1'b1;
            end
         end
      end
      return res;
   endfunction

   function automatic void compare_field(input string name, input logic [FIELD_W-1:0] want,
                                         input logic [FIELD_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Driver: one request per item, with a random gap after each
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (!start || req_taken) begin
         if (gap_left != 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_requests.size() != 0) begin
            req_data <= pending_requests.pop_front();
            start <= 1'b1;
            gap_left <= $urandom_range(0, gap_max);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check results, predict accepted requests, track register writes
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
         cfg_sym = 1'b0;
         cfg_bal = 1'b0;
         cfg_active = ACTIVE_W'(1);
         foreach (irq_counts[c, q])
            irq_counts[c][q] = '0;
      end else begin
         if (rsp_valid !== 1'b0) begin
            if (expected_routing.size() == 0) begin
               errors++;
               $display("%0t: result with none expected, expected nothing, actual %p",
                        $time, rsp_data);
            end else begin
               want = expected_routing.pop_front();
               compare_field("eoi_to_apic", want.eoi_to_apic, rsp_data.eoi_to_apic);
               compare_field("route_valid", want.route_valid, rsp_data.route_valid);
               compare_field("route_core", want.route_core, rsp_data.route_core);
               compare_field("counts_cleared", want.counts_cleared, rsp_data.counts_cleared);
            end
         end
         req_taken <= start && !busy;
         if (start && !busy)
            expected_routing.push_back(route_request(req_data));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SYM_MODE: cfg_sym = csr_data[0];
               CSR_BAL_EN:   cfg_bal = csr_data[0];
               CSR_ACTIVE:   cfg_active = csr_data[ACTIVE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic queue_burst(input logic [FIELD_W-1:0] core, input logic [FIELD_W-1:0] irq,
                              input int reps);
      req_type r;
      r.core_id = core;
      r.irq = irq;
      repeat (reps) pending_requests.push_back(r);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hold off until every request is out and every result is back
   task automatic drain();
      while (pending_requests.size() != 0 || start || expected_routing.size() != 0
             || busy !== 1'b0)
         @(negedge clock);
   endtask

   // Stimulus
   initial begin
      logic sym;
      logic bal;
      logic [ACTIVE_W-1:0] act;
      int span;
      int queued;
      int kind;
      int reps;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // field extremes with the reset settings
      queue_burst(4'd0, 4'd0, 1);
      queue_burst(4'd15, 4'd15, 1);
      queue_burst(4'd0, 4'd15, 1);
      queue_burst(4'd15, 4'd0, 1);
      queue_burst(4'd5, 4'd10, 1);
      queue_burst(4'd10, 4'd5, 1);

      // no active cores: the tenth hit reroutes to core 0 and scans nothing
      drain();
      write_reg(CSR_SYM_MODE, 8'hFF);
      write_reg(CSR_BAL_EN, 8'h81);
      write_reg(CSR_ACTIVE, 8'hE0);
      queue_burst(4'd3, 4'd2, 10);

      // active count above the core count scans all cores
      drain();
      write_reg(CSR_ACTIVE, 8'h3F);
      write_reg(CSR_UNUSED, 8'h5A);
      queue_burst(4'd15, 4'd0, 9);

      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         drain();
         sym = 1'($urandom_range(0, 1));
         bal = ($urandom_range(0, 4) != 0);
         case ($urandom_range(0, 4))
            0: act = 5'd0;
            1: act = 5'd1;
            2: act = 5'd16;
            3: act = 5'($urandom_range(17, 31));
            default: act = 5'($urandom_range(2, 15));
         endcase
         write_reg(CSR_ACTIVE, {3'($urandom), act});
         write_reg(CSR_SYM_MODE, {7'($urandom), sym});
         write_reg(CSR_BAL_EN, {7'($urandom), bal});
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_UNUSED, 8'($urandom));
         gap_max = (phase % 3 == 1) ? 0 : 12;
         span = (act == 0) ? 1 : ((act > NUM_CORES) ? NUM_CORES : int'(act));

         // mostly bursts on a few hot IRQs so counts cross the period often
         queued = 0;
         while (queued < PHASE_ITEMS) begin
            kind = $urandom_range(0, 19);
            if (kind < 3) begin
               queue_burst(4'($urandom), 4'($urandom), 1);
               queued++;
            end else begin
               reps = (kind < 12) ? $urandom_range(1, 10) : 1;
               queue_burst(4'($urandom_range(0, span - 1)), 4'($urandom_range(0, 3)), reps);
               queued += reps;
            end
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/llir_pkg.sv
hdl/llir_cnt_mem.sv
hdl/llir_mod_unit.sv
hdl/llir_ctrl.sv
hdl/least_loaded_interrupt_router.sv
hdl/llir_checker.sv
tb/tb_least_loaded_interrupt_router.sv
